// File: rtl/egcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Extended GCD package
// Shared types and widths for the extended Euclidean core.
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int DW = 33;
    localparam int CW = 34;
    localparam int CNTW = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_FIN,
        ST_INV,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// File: rtl/extended_gcd_mod_inverse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Extended GCD and modular inverse core
// Iterative extended Euclid with a bit-serial divider and shift-add multiplier.
// ----------------------------------------------------------------------------
// Each Euclid step sets up the divider, runs its 33-step shift-subtract, then the
// shift-add multiplier one quotient bit at a time, then the update; when an inverse
// exists, a final reduction through the divider follows.
// One word is processed at a time; busy is high throughout. Results appear for
// one cycle on o_done and cannot be stalled. Reset returns the sequencer to idle.
module extended_gcd_mod_inverse_core #(
    parameter int WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    output logic             o_done,
    output logic [30:0]      o_gcd_value,
    output logic [31:0]      o_coef_x,
    output logic [31:0]      o_coef_y,
    output logic [30:0]      o_inverse,
    output logic             o_inverse_valid
);
    import egcd_pkg::*;

    localparam int   IW  = (WIDTH < 32) ? WIDTH : 32;
    localparam logic SGN = (WIDTH <= 32);

    t_state r_state, n_state;

    logic signed [DW-1:0] r_a, r_b, r_m;
    logic signed [CW-1:0] r_x, r_y, r_x1, r_y1;
    logic [CW-1:0]        r_px, r_py, r_mx, r_my;
    logic [DW-1:0]        r_q, r_dd, r_dv, r_rem;
    logic [CNTW-1:0]      r_cnt;
    logic                 r_qneg;
    logic                 r_xneg;
    logic [30:0]          r_gcd, r_inv;
    logic [31:0]          r_cx, r_cy;
    logic                 r_valid;

    logic signed [DW-1:0] ext_a, ext_b, mag_a, mag_b, nb;
    logic [DW:0]          rem_sh;
    logic                 ge;
    logic signed [CW-1:0] fx, fy, mag_fx;
    logic                 fneg;

    assign ext_a  = {{(DW-IW){SGN & i_operand_a[IW-1]}}, i_operand_a[IW-1:0]};
    assign ext_b  = {{(DW-IW){SGN & i_operand_b[IW-1]}}, i_operand_b[IW-1:0]};
    assign mag_a  = r_a[DW-1] ? -r_a : r_a;
    assign mag_b  = r_b[DW-1] ? -r_b : r_b;
    assign rem_sh = {r_rem, r_dd[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_dv};
    assign nb     = r_a[DW-1] ? -$signed(r_rem) : $signed(r_rem);
    assign fneg   = (r_a == '0) || r_a[DW-1];
    assign fx     = fneg ? -r_x : r_x;
    assign fy     = fneg ? -r_y : r_y;
    assign mag_fx = fx[CW-1] ? -fx : fx;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_START;
            ST_START: n_state = (r_b == '0) ? ST_FIN : ST_DIV;
            ST_DIV:   if (r_cnt == CNTW'(DW - 1)) n_state = r_valid ? ST_INV : ST_MUL;
            ST_MUL:   if (r_q == '0) n_state = ST_UPD;
            ST_UPD:   n_state = ST_START;
            ST_FIN:   n_state = ((r_m > 0) && (mag_a == DW'(1))) ? ST_DIV : ST_DONE;
            ST_INV:   n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy   = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_a     <= ext_a;
                        r_b     <= ext_b;
                        r_m     <= ext_b;
                        r_x     <= CW'(1);
                        r_y     <= '0;
                        r_x1    <= '0;
                        r_y1    <= CW'(1);
                        r_valid <= 1'b0;
                    end
                end
                ST_START: begin
                    r_dd   <= mag_a;
                    r_dv   <= mag_b;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_cnt  <= '0;
                    r_qneg <= r_a[DW-1] ^ r_b[DW-1];
                end
                ST_DIV: begin
                    r_rem <= ge ? DW'(rem_sh - {1'b0, r_dv}) : DW'(rem_sh);
                    r_q   <= {r_q[DW-2:0], ge};
                    r_dd  <= {r_dd[DW-2:0], 1'b0};
                    r_cnt <= r_cnt + CNTW'(1);
                    r_px  <= '0;
                    r_py  <= '0;
                    r_mx  <= r_x1;
                    r_my  <= r_y1;
                end
                ST_MUL: begin
                    if (r_q[0]) begin
                        r_px <= r_px + r_mx;
                        r_py <= r_py + r_my;
                    end
                    r_mx <= {r_mx[CW-2:0], 1'b0};
                    r_my <= {r_my[CW-2:0], 1'b0};
                    r_q  <= {1'b0, r_q[DW-1:1]};
                end
                ST_UPD: begin
                    r_x  <= r_x1;
                    r_y  <= r_y1;
                    r_x1 <= r_qneg ? r_x + $signed(r_px) : r_x - $signed(r_px);
                    r_y1 <= r_qneg ? r_y + $signed(r_py) : r_y - $signed(r_py);
                    r_a  <= r_b;
                    r_b  <= nb;
                end
                ST_FIN: begin
                    r_gcd   <= mag_a[30:0];
                    r_cx    <= fx[31:0];
                    r_cy    <= fy[31:0];
                    r_inv   <= '0;
                    r_xneg  <= fx[CW-1];
                    r_valid <= (r_m > 0) && (mag_a == DW'(1));
                    r_dd    <= mag_fx[DW-1:0];
                    r_dv    <= r_m;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                end
                ST_INV: begin
                    r_inv <= (r_xneg && (r_rem != '0)) ? 31'(r_dv - r_rem) : r_rem[30:0];
                end
                ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_gcd_value     = r_gcd;
    assign o_coef_x        = r_cx;
    assign o_coef_y        = r_cy;
    assign o_inverse       = r_inv;
    assign o_inverse_valid = r_valid;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("core busy after result");
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_inverse_valid) |-> (o_inverse == '0))
        else $error("inverse not cleared");
    a_valid_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_inverse_valid) |-> (o_gcd_value == 31'd1))
        else $error("inverse valid without unit gcd");

endmodule
`default_nettype wire

// File: bench/tb_extended_gcd_mod_inverse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extended GCD core testbench
// Drives signed operand pairs into the core, predicts gcd, Bezout coefficients
// and modular inverse for each accepted word, and checks every result word.
// ----------------------------------------------------------------------------
module tb_extended_gcd_mod_inverse_core;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_operands;

    typedef struct packed {
        logic [30:0] gcd;
        logic [31:0] x;
        logic [31:0] y;
        logic [30:0] inv;
        logic        inv_ok;
    } t_egcd_result;

    localparam int CYCLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    wire         busy;
    wire         o_done;
    wire  [30:0] o_gcd_value;
    wire  [31:0] o_coef_x;
    wire  [31:0] o_coef_y;
    wire  [30:0] o_inverse;
    wire         o_inverse_valid;

    t_operands    pending_words[$];
    t_egcd_result expected_results[$];
    int           idle_percent = 0;
    bit           hold_off = 1'b0;
    bit           stimulus_done = 1'b0;
    int           mismatches = 0;
    int           results_seen = 0;
    int           inverses_seen = 0;
    longint       cycles = 0;

    extended_gcd_mod_inverse_core #(.WIDTH(32)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operand_a(i_operand_a), .i_operand_b(i_operand_b), .o_done(o_done),
        .o_gcd_value(o_gcd_value), .o_coef_x(o_coef_x), .o_coef_y(o_coef_y),
        .o_inverse(o_inverse), .o_inverse_valid(o_inverse_valid)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_egcd_result predict_egcd(t_operands w);
        longint r0, r1, s0, s1, t0, t1, q, nr, ns, nt, m, rem;
        t_egcd_result res;
        r0 = longint'(signed'(w.a));
        r1 = longint'(signed'(w.b));
        m = r1;
        s0 = 1; t0 = 0; s1 = 0; t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            nr = r0 - q * r1;
            ns = s0 - q * s1;
            nt = t0 - q * t1;
            r0 = r1; s0 = s1; t0 = t1;
            r1 = nr; s1 = ns; t1 = nt;
        end
        if (r0 <= 0) begin
            s0 = -s0;
            t0 = -t0;
        end
        if (r0 < 0) r0 = -r0;
        res.gcd = r0[30:0];
        res.x = s0[31:0];
        res.y = t0[31:0];
        res.inv_ok = (m > 0) && (r0 == 1);
        res.inv = '0;
        if (res.inv_ok) begin
            rem = s0 % m;
            if (rem < 0) rem = rem + m;
            res.inv = rem[30:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 20);
            1: v = -$urandom_range(1, 20);
            2: v = $urandom_range(0, 65535);
            default: v = $urandom;
        endcase
        if (v == 32'h8000_0000) v = 32'h8000_0001;
        return v;
    endfunction

    always @(negedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && !busy && !start && !hold_off && pending_words.size() != 0
                && $urandom_range(0, 99) >= idle_percent) begin
            t_operands w;
            w = pending_words.pop_front();
            i_operand_a <= w.a;
            i_operand_b <= w.b;
            start <= 1'b1;
        end else if (start && !busy) begin
            start <= 1'b1;
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_results.push_back(predict_egcd({i_operand_a, i_operand_b}));
        end
        if (i_rst_n && o_done) begin
            t_egcd_result want;
            t_egcd_result got;
            got = {o_gcd_value, o_coef_x, o_coef_y, o_inverse, o_inverse_valid};
            results_seen++;
            if (o_inverse_valid) inverses_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Result differs: expected %p, got %p",
                                                   want, got);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("extended_gcd_mod_inverse_core: mismatch");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || start || busy || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int phase_idle[4];
        int k;
        phase_idle = '{0, 79, 0, 29};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        pending_words.push_back({32'd0, 32'd0});
        pending_words.push_back({32'd5, 32'd1});
        pending_words.push_back({32'd3, 32'd7});
        pending_words.push_back({-32'sd3, 32'd7});
        pending_words.push_back({32'd3, -32'sd7});
        pending_words.push_back({32'd4, 32'd8});
        pending_words.push_back({32'd0, 32'd7});
        pending_words.push_back({32'd7, 32'd0});
        pending_words.push_back({-32'sd7, 32'd0});
        pending_words.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFE});
        pending_words.push_back({32'h8000_0001, 32'h7FFF_FFFF});
        pending_words.push_back({32'h8000_0001, 32'h8000_0001});
        pending_words.push_back({32'd1134903170, 32'd1836311903});
        pending_words.push_back({32'd1836311903, 32'd1134903170});
        pending_words.push_back({32'h7FFF_FFFF, 32'd1});
        pending_words.push_back({32'd6, 32'hFFFF_FFFF});
        pending_words.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_words.push_back({32'd10, 32'd2147483647});
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            idle_percent = phase_idle[p];
            for (k = 0; k < 90; k++)
                pending_words.push_back({random_operand(), random_operand()});
            if (p == 1) begin
                while (pending_words.size() > 45) @(posedge i_clk);
                hold_off = 1'b1;
                while (start || busy || expected_results.size() != 0) @(posedge i_clk);
                @(negedge i_clk) hold_off = 1'b0;
            end
            wait_drained();
        end
        repeat (2000) @(posedge i_clk);

        $display("Checked %0d result words, %0d with an inverse, over four idling phases.",
                 results_seen, inverses_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("extended_gcd_mod_inverse_core: match");
        end else begin
            $display("extended_gcd_mod_inverse_core: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/egcd_pkg.sv
rtl/extended_gcd_mod_inverse_core.sv
bench/tb_extended_gcd_mod_inverse_core.sv
